// ===== hdl/dpg_pkg.sv =====
// ----------------------------------------------------------------------------
// dpg_pkg
// shared constants, pipeline control type and a max helper for the disc
// potential and gradient unit
// ----------------------------------------------------------------------------
package dpg_pkg;

  // default number of fraction bits of the fixed point format
  localparam int DefFracBits = 24;

  // field widths
  localparam int UW = 31;  // unsigned fields and registers
  localparam int SW = 32;  // signed fields

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_SCALE_A   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT_SQ = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_GRAV_MASS = 2'd2;

  // control that every pipelined unit receives
  typedef struct packed {
    logic adv;  // whole pipeline moves one stage
    logic vld;  // transaction presented at the unit input
  } dpg_ctrl_t;

  function automatic int dpg_max(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

endpackage

// ===== hdl/disc_potential_and_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// disc_potential_and_gradient_unit
// disc potential -GM/S with its radial and vertical derivatives, Q format
// fixed point, saturated results
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid_i / in_ready_o with radius_i and height_i
//   output channel : out_valid_o / out_ready_i with potential_o,
//                    grad_radial_o, grad_vertical_o and saturated_o
//   config port    : cfg_we_i, cfg_idx_i, cfg_data_i; written while idle,
//                    unknown indexes are ignored
//   throughput     : one transaction per cycle while the pipe is not frozen
//   pipeline       : the bit-serial stages, one per root bit in the two
//                    square roots and one per quotient bit in the three
//                    chained dividers, plus eighteen capture, multiply and
//                    clipping register stages
//   reset          : all valid bits clear, config registers return to 1.0
//   stall          : a result waiting at the output does not stop the pipe;
//                    a second one parks in a skid register and only then
//                    is in_ready_o dropped and the whole pipe frozen
//   singular point : R = a = z = b^2 = 0 gives -2^31 (or 0 for zero GM)
// ----------------------------------------------------------------------------
module disc_potential_and_gradient_unit #(
  parameter int FRAC_BITS = dpg_pkg::DefFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dpg_pkg::UW-1:0]       cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dpg_pkg::UW-1:0]       radius_i,
  input  logic signed [dpg_pkg::SW-1:0] height_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [dpg_pkg::SW-1:0] potential_o,
  output logic [dpg_pkg::UW-1:0]       grad_radial_o,
  output logic signed [dpg_pkg::SW-1:0] grad_vertical_o,
  output logic                         saturated_o
);
  import dpg_pkg::*;

  // intermediate widths follow the fraction bits
  localparam int ZB2_W = dpg_max(2 * SW, UW + FRAC_BITS) + 1;  // z^2 + b^2
  localparam int ZB_W  = (ZB2_W + 1) / 2;                      // sqrt of it
  localparam int AZB_W = dpg_max(ZB_W, UW) + 1;                // a + zb
  localparam int R2_W  = 2 * UW;
  localparam int DEN_W = dpg_max(2 * AZB_W, R2_W) + 1;         // R^2 + azb^2
  localparam int S_W   = (DEN_W + 1) / 2;
  localparam int GN_W  = UW + FRAC_BITS;                       // gm << F
  localparam int PR_W  = 2 * SW;                               // q*R, q*|z|
  localparam int T_W   = SW + 1;                               // t <= 2^32
  localparam int MN_W  = T_W + AZB_W;                          // t * azb

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [UW-1:0] a_q, b2_q, gm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= UW'(64'd1 << FRAC_BITS);
      b2_q <= UW'(64'd1 << FRAC_BITS);
      gm_q <= UW'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE_A:   a_q  <= cfg_data_i;
        REG_HEIGHT_SQ: b2_q <= cfg_data_i;
        REG_GRAV_MASS: gm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: the pipe moves whenever the skid register is empty
  // --------------------------------------------------------------------------
  logic skid_vld_q, out_vld_q;
  logic adv;

  assign adv        = !skid_vld_q;
  assign in_ready_o = adv;

  // sideband bundles carried alongside the arithmetic units
  typedef struct packed {
    logic            neg;
    logic [SW-1:0]   zm;
    logic [UW-1:0]   r;
    logic [R2_W-1:0] r2;
  } side_a_t;

  typedef struct packed {
    logic             neg;
    logic [SW-1:0]    zm;
    logic [UW-1:0]    r;
    logic [ZB_W-1:0]  zb;
    logic [AZB_W-1:0] azb;
  } side_b_t;

  typedef struct packed {
    side_b_t          b;
    logic [DEN_W-1:0] den2;
  } side_c_t;

  typedef struct packed {
    side_c_t c;
    logic    s_zero;
  } side_d_t;

  typedef struct packed {
    logic             neg;
    logic [ZB_W-1:0]  zb;
    logic [AZB_W-1:0] azb;
    logic [DEN_W-1:0] den2;
    logic             s_zero;
    logic [SW-1:0]    pot;
  } side_e_t;

  typedef struct packed {
    logic            neg;
    logic [ZB_W-1:0] zb;
    logic            s_zero;
    logic [SW-1:0]   pot;
    logic [UW-1:0]   gr;
    logic            sat;
  } side_g_t;

  typedef struct packed {
    logic          neg;
    logic          zb_zero;
    logic          s_zero;
    logic [SW-1:0] pot;
    logic [UW-1:0] gr;
    logic          sat;
  } side_m_t;

  typedef struct packed {
    logic [SW-1:0] pot;
    logic [UW-1:0] gr;
    logic [SW-1:0] gz;
    logic          sat;
  } result_t;

  // --------------------------------------------------------------------------
  // input stage: |z| and R^2
  // --------------------------------------------------------------------------
  logic            in_vld_q;
  side_a_t         in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.neg <= height_i[SW-1];
      in_q.zm  <= height_i[SW-1] ? SW'(-height_i) : SW'(height_i);
      in_q.r   <= radius_i;
      in_q.r2  <= R2_W'(radius_i) * R2_W'(radius_i);
    end
  end

  // --------------------------------------------------------------------------
  // zb = sqrt(z^2 + b^2)
  // --------------------------------------------------------------------------
  dpg_ctrl_t        ctrl_ma, ctrl_sa;
  logic             ma_vld, sa_vld;
  logic [ZB2_W-1:0] zb2;
  side_a_t          ma_side, sa_side;
  logic [ZB_W-1:0]  zb;

  assign ctrl_ma = '{adv: adv, vld: in_vld_q};

  dpg_mul2 #(
    .AW(SW), .BW(SW), .CW(UW + FRAC_BITS), .PW(ZB2_W), .SBW($bits(side_a_t))
  ) u_mul_zsq (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_ma),
    .a_i     (in_q.zm),
    .b_i     (in_q.zm),
    .c_i     ({b2_q, {FRAC_BITS{1'b0}}}),
    .side_i  (in_q),
    .valid_o (ma_vld),
    .p_o     (zb2),
    .side_o  (ma_side)
  );

  assign ctrl_sa = '{adv: adv, vld: ma_vld};

  dpg_sqrt #(.IW(ZB2_W), .SBW($bits(side_a_t)), .OW(ZB_W)) u_sqrt_zb (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_sa),
    .rad_i   (zb2),
    .side_i  (ma_side),
    .valid_o (sa_vld),
    .root_o  (zb),
    .side_o  (sa_side)
  );

  // --------------------------------------------------------------------------
  // azb = a + zb
  // --------------------------------------------------------------------------
  logic            az_vld_q;
  side_b_t         az_q;
  logic [R2_W-1:0] az_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_vld_q <= 1'b0;
    end else if (adv) begin
      az_vld_q <= sa_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      az_q.neg <= sa_side.neg;
      az_q.zm  <= sa_side.zm;
      az_q.r   <= sa_side.r;
      az_q.zb  <= zb;
      az_q.azb <= AZB_W'(a_q) + AZB_W'(zb);
      az_r2_q  <= sa_side.r2;
    end
  end

  // --------------------------------------------------------------------------
  // den2 = R^2 + azb^2, s = sqrt(den2)
  // --------------------------------------------------------------------------
  dpg_ctrl_t        ctrl_mb, ctrl_sb, ctrl_dq;
  logic             mb_vld, sb_vld, dq_vld;
  logic [DEN_W-1:0] den2;
  side_b_t          mb_side;
  side_c_t          sb_in, sb_side;
  logic [S_W-1:0]   s_root;
  side_d_t          dq_in, dq_side;
  logic [GN_W-1:0]  q_full;

  assign ctrl_mb = '{adv: adv, vld: az_vld_q};

  dpg_mul2 #(
    .AW(AZB_W), .BW(AZB_W), .CW(R2_W), .PW(DEN_W), .SBW($bits(side_b_t))
  ) u_mul_den (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_mb),
    .a_i     (az_q.azb),
    .b_i     (az_q.azb),
    .c_i     (az_r2_q),
    .side_i  (az_q),
    .valid_o (mb_vld),
    .p_o     (den2),
    .side_o  (mb_side)
  );

  assign ctrl_sb    = '{adv: adv, vld: mb_vld};
  assign sb_in.b    = mb_side;
  assign sb_in.den2 = den2;

  dpg_sqrt #(.IW(DEN_W), .SBW($bits(side_c_t)), .OW(S_W)) u_sqrt_s (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_sb),
    .rad_i   (den2),
    .side_i  (sb_in),
    .valid_o (sb_vld),
    .root_o  (s_root),
    .side_o  (sb_side)
  );

  // --------------------------------------------------------------------------
  // q = gm * 2^F / s
  // --------------------------------------------------------------------------
  assign ctrl_dq      = '{adv: adv, vld: sb_vld};
  assign dq_in.c      = sb_side;
  assign dq_in.s_zero = (s_root == '0);

  dpg_div #(.NW(GN_W), .DW(S_W), .SBW($bits(side_d_t))) u_div_q (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_dq),
    .num_i   ({gm_q, {FRAC_BITS{1'b0}}}),
    .den_i   (s_root),
    .side_i  (dq_in),
    .valid_o (dq_vld),
    .quo_o   (q_full),
    .side_o  (dq_side)
  );

  // clip q to 2^31 and form the potential
  logic            qc_vld_q;
  logic [SW-1:0]   qc_q;
  logic            qc_sat_q;
  logic [UW-1:0]   qc_r_q;
  logic [SW-1:0]   qc_zm_q;
  side_e_t         qc_side_q;
  logic            q_big;
  logic [SW-1:0]   q_clip;

  assign q_big  = (q_full > GN_W'(64'd1 << UW));
  assign q_clip = q_big ? (SW'(1) << UW) : q_full[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_vld_q <= 1'b0;
    end else if (adv) begin
      qc_vld_q <= dq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qc_q             <= q_clip;
      qc_sat_q         <= q_big;
      qc_r_q           <= dq_side.c.b.r;
      qc_zm_q          <= dq_side.c.b.zm;
      qc_side_q.neg    <= dq_side.c.b.neg;
      qc_side_q.zb     <= dq_side.c.b.zb;
      qc_side_q.azb    <= dq_side.c.b.azb;
      qc_side_q.den2   <= dq_side.c.den2;
      qc_side_q.s_zero <= dq_side.s_zero;
      qc_side_q.pot    <= SW'(-q_clip);
    end
  end

  // --------------------------------------------------------------------------
  // gr = q*R / den2 and t = q*|z| / den2, two lanes in lock step
  // --------------------------------------------------------------------------
  dpg_ctrl_t       ctrl_mc, ctrl_dr, ctrl_dt;
  logic            mc_vld, md_vld, dr_vld, dt_vld;
  logic [PR_W-1:0] qr, qz, gr_full, t_full;
  side_e_t         mc_side, dr_side;
  logic            md_sat, dt_sat;

  assign ctrl_mc = '{adv: adv, vld: qc_vld_q};

  dpg_mul2 #(
    .AW(SW), .BW(UW), .CW(1), .PW(PR_W), .SBW($bits(side_e_t))
  ) u_mul_qr (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_mc),
    .a_i     (qc_q),
    .b_i     (qc_r_q),
    .c_i     (1'b0),
    .side_i  (qc_side_q),
    .valid_o (mc_vld),
    .p_o     (qr),
    .side_o  (mc_side)
  );

  dpg_mul2 #(.AW(SW), .BW(SW), .CW(1), .PW(PR_W), .SBW(1)) u_mul_qz (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_mc),
    .a_i     (qc_q),
    .b_i     (qc_zm_q),
    .c_i     (1'b0),
    .side_i  (qc_sat_q),
    .valid_o (md_vld),
    .p_o     (qz),
    .side_o  (md_sat)
  );

  assign ctrl_dr = '{adv: adv, vld: mc_vld};
  assign ctrl_dt = '{adv: adv, vld: md_vld};

  dpg_div #(.NW(PR_W), .DW(DEN_W), .SBW($bits(side_e_t))) u_div_gr (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_dr),
    .num_i   (qr),
    .den_i   (mc_side.den2),
    .side_i  (mc_side),
    .valid_o (dr_vld),
    .quo_o   (gr_full),
    .side_o  (dr_side)
  );

  dpg_div #(.NW(PR_W), .DW(DEN_W), .SBW(1)) u_div_t (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_dt),
    .num_i   (qz),
    .den_i   (mc_side.den2),
    .side_i  (md_sat),
    .valid_o (dt_vld),
    .quo_o   (t_full),
    .side_o  (dt_sat)
  );

  // clip gr to the field and t to 2^32
  logic             gc_vld_q;
  logic [T_W-1:0]   gc_t_q;
  logic [AZB_W-1:0] gc_azb_q;
  side_g_t          gc_side_q;
  logic             gr_big, t_big;

  assign gr_big = (gr_full > PR_W'({UW{1'b1}}));
  assign t_big  = (t_full > (PR_W'(1) << SW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_vld_q <= 1'b0;
    end else if (adv) begin
      gc_vld_q <= dr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gc_t_q           <= t_big ? (T_W'(1) << SW) : t_full[T_W-1:0];
      gc_azb_q         <= dr_side.azb;
      gc_side_q.neg    <= dr_side.neg;
      gc_side_q.zb     <= dr_side.zb;
      gc_side_q.s_zero <= dr_side.s_zero;
      gc_side_q.pot    <= dr_side.pot;
      gc_side_q.gr     <= gr_big ? {UW{1'b1}} : gr_full[UW-1:0];
      gc_side_q.sat    <= dt_sat | gr_big;
    end
  end

  // --------------------------------------------------------------------------
  // gz magnitude = t * azb / zb
  // --------------------------------------------------------------------------
  dpg_ctrl_t       ctrl_me, ctrl_dm;
  logic            me_vld, dm_vld;
  logic [MN_W-1:0] tm, m_full;
  side_g_t         me_side;
  side_m_t         dm_in, dm_side;

  assign ctrl_me = '{adv: adv, vld: gc_vld_q};

  dpg_mul2 #(
    .AW(T_W), .BW(AZB_W), .CW(1), .PW(MN_W), .SBW($bits(side_g_t))
  ) u_mul_tm (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_me),
    .a_i     (gc_t_q),
    .b_i     (gc_azb_q),
    .c_i     (1'b0),
    .side_i  (gc_side_q),
    .valid_o (me_vld),
    .p_o     (tm),
    .side_o  (me_side)
  );

  assign ctrl_dm       = '{adv: adv, vld: me_vld};
  assign dm_in.neg     = me_side.neg;
  assign dm_in.zb_zero = (me_side.zb == '0);
  assign dm_in.s_zero  = me_side.s_zero;
  assign dm_in.pot     = me_side.pot;
  assign dm_in.gr      = me_side.gr;
  assign dm_in.sat     = me_side.sat;

  dpg_div #(.NW(MN_W), .DW(ZB_W), .SBW($bits(side_m_t))) u_div_m (
    .clk_i, .rst_ni,
    .ctrl_i  (ctrl_dm),
    .num_i   (tm),
    .den_i   (me_side.zb),
    .side_i  (dm_in),
    .valid_o (dm_vld),
    .quo_o   (m_full),
    .side_o  (dm_side)
  );

  // --------------------------------------------------------------------------
  // final clip, sign and singular point
  // --------------------------------------------------------------------------
  logic [MN_W-1:0] m_lim;
  logic            m_big;
  logic [SW-1:0]   m_clip;
  logic            gm_nz;
  result_t         res_d;

  assign m_lim  = dm_side.neg ? (MN_W'(1) << UW) : MN_W'({UW{1'b1}});
  assign m_big  = (m_full > m_lim);
  assign m_clip = m_big ? m_lim[SW-1:0] : m_full[SW-1:0];
  assign gm_nz  = (gm_q != '0);

  always_comb begin
    res_d.pot = dm_side.pot;
    res_d.gr  = dm_side.gr;
    res_d.gz  = '0;
    res_d.sat = dm_side.sat;
    if (!dm_side.zb_zero) begin
      res_d.gz  = dm_side.neg ? SW'(-m_clip) : m_clip;
      res_d.sat = dm_side.sat | m_big;
    end
    if (dm_side.s_zero) begin
      // R, a, z and b^2 all zero
      res_d.pot = gm_nz ? (SW'(1) << UW) : '0;
      res_d.gr  = '0;
      res_d.gz  = '0;
      res_d.sat = gm_nz;
    end
  end

  // --------------------------------------------------------------------------
  // output register with skid register behind it
  // --------------------------------------------------------------------------
  result_t out_q, skid_q;
  logic    take_new;

  assign take_new = adv && dm_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && !out_ready_i) begin
      skid_vld_q <= take_new;
    end else begin
      out_vld_q <= take_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && !out_ready_i) begin
      skid_q <= res_d;
    end else if (take_new) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign potential_o     = out_q.pot;
  assign grad_radial_o   = out_q.gr;
  assign grad_vertical_o = out_q.gz;
  assign saturated_o     = out_q.sat;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a transaction with the output empty");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !out_ready_i))
    else $error("skid register filled while the output was free");

  a_skid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_ready_i |=> skid_vld_q)
    else $error("skid register dropped a transaction under stall");

  a_lanes_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mc_vld == md_vld) && (dr_vld == dt_vld))
    else $error("gradient lanes out of step");

endmodule

// ===== hdl/dpg_mul2.sv =====
// ----------------------------------------------------------------------------
// dpg_mul2
// two stage multiply-add, p = a * b + c, split into two partial products
// ----------------------------------------------------------------------------
module dpg_mul2 #(
  parameter int AW  = 32,
  parameter int BW  = 32,
  parameter int CW  = 1,
  parameter int PW  = 64,
  parameter int SBW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpg_pkg::dpg_ctrl_t ctrl_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  input  logic [CW-1:0]      c_i,
  input  logic [SBW-1:0]     side_i,
  output logic               valid_o,
  output logic [PW-1:0]      p_o,
  output logic [SBW-1:0]     side_o
);
  import dpg_pkg::*;

  localparam int LW = BW / 2;
  localparam int HW = BW - LW;
  localparam int FW = dpg_max(AW + BW, CW) + 1;

  logic               v1_q, v2_q;
  logic [AW+LW-1:0]   lo_q;
  logic [AW+HW-1:0]   hi_q;
  logic [CW-1:0]      c_q;
  logic [SBW-1:0]     s1_q, s2_q;
  logic [PW-1:0]      p_q;
  logic [FW-1:0]      sum_d;

  assign sum_d = FW'(lo_q) + (FW'(hi_q) << LW) + FW'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      v1_q <= ctrl_i.vld;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      lo_q <= (AW+LW)'(a_i) * (AW+LW)'(b_i[LW-1:0]);
      hi_q <= (AW+HW)'(a_i) * (AW+HW)'(b_i[BW-1:LW]);
      c_q  <= c_i;
      s1_q <= side_i;
      p_q  <= sum_d[PW-1:0];
      s2_q <= s1_q;
    end
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign side_o  = s2_q;

endmodule

// ===== hdl/dpg_sqrt.sv =====
// ----------------------------------------------------------------------------
// dpg_sqrt
// pipelined integer square root, one root bit per stage, floor rounding
// ----------------------------------------------------------------------------
module dpg_sqrt #(
  parameter int IW  = 65,
  parameter int SBW = 1,
  parameter int OW  = (IW + 1) / 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpg_pkg::dpg_ctrl_t ctrl_i,
  input  logic [IW-1:0]      rad_i,
  input  logic [SBW-1:0]     side_i,
  output logic               valid_o,
  output logic [OW-1:0]      root_o,
  output logic [SBW-1:0]     side_o
);
  import dpg_pkg::*;

  logic [2*OW-1:0] rad_q  [0:OW];
  logic [OW:0]     rem_q  [0:OW];
  logic [OW-1:0]   root_q [0:OW];
  logic [SBW-1:0]  side_q [0:OW];
  logic            vld_q  [0:OW];

  // input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctrl_i.adv) begin
      vld_q[0] <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      rad_q[0]  <= (2*OW)'(rad_i);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW+2:0] cur_d;
    logic [OW+2:0] trial_d;
    logic          take_d;

    // bring down two radicand bits and try the next root bit
    assign cur_d   = {rem_q[k], rad_q[k][2*OW-1 -: 2]};
    assign trial_d = (OW+3)'({root_q[k], 2'b01});
    assign take_d  = (cur_d >= trial_d);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctrl_i.adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        rad_q[k+1]  <= rad_q[k] << 2;
        rem_q[k+1]  <= take_d ? (OW+1)'(cur_d - trial_d) : cur_d[OW:0];
        root_q[k+1] <= {root_q[k][OW-2:0], take_d};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[OW];
  assign root_o  = root_q[OW];
  assign side_o  = side_q[OW];

endmodule

// ===== hdl/dpg_div.sv =====
// ----------------------------------------------------------------------------
// dpg_div
// pipelined restoring divider, one quotient bit per stage, floor rounding
// ----------------------------------------------------------------------------
module dpg_div #(
  parameter int NW  = 64,
  parameter int DW  = 32,
  parameter int SBW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpg_pkg::dpg_ctrl_t ctrl_i,
  input  logic [NW-1:0]      num_i,
  input  logic [DW-1:0]      den_i,
  input  logic [SBW-1:0]     side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SBW-1:0]     side_o
);
  import dpg_pkg::*;

  logic [NW-1:0]  num_q  [0:NW];
  logic [NW-1:0]  quo_q  [0:NW];
  logic [DW-1:0]  rem_q  [0:NW];
  logic [DW-1:0]  den_q  [0:NW];
  logic [SBW-1:0] side_q [0:NW];
  logic           vld_q  [0:NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctrl_i.adv) begin
      vld_q[0] <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      num_q[0]  <= num_i;
      quo_q[0]  <= '0;
      rem_q[0]  <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] cur_d;
    logic        take_d;

    assign cur_d  = {rem_q[k], num_q[k][NW-1]};
    assign take_d = (cur_d >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctrl_i.adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.adv) begin
        num_q[k+1]  <= num_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][NW-2:0], take_d};
        rem_q[k+1]  <= take_d ? DW'(cur_d - {1'b0, den_q[k]}) : cur_d[DW-1:0];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = quo_q[NW];
  assign side_o  = side_q[NW];

endmodule
